### hdl/sslte_pkg.sv
// ----------------------------------------------------------------------------
// sslte_pkg: shared types and constants for the servo slew limiter
// Item, frame, queue entry and configuration structs, state and code enums.
// ----------------------------------------------------------------------------
package sslte_pkg;

    typedef struct packed {
        logic               func;
        logic [1:0]         servo_index;
        logic signed [15:0] angle;
        logic [31:0]        now_us;
    } item_t;

    typedef struct packed {
        logic [3:0] high_bits;
        logic [7:0] slot0_low;
        logic [7:0] slot1_low;
        logic [7:0] slot2_low;
        logic [7:0] slot3_low;
    } frame_t;

    typedef enum logic {
        FUNC_SET  = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [1:0]         servo_index;
        logic signed [15:0] angle;
        logic [31:0]        now_us;
    } q_entry_t;

    typedef struct packed {
        logic signed [13:0] angle_min;
        logic [12:0]        angle_max;
        logic [15:0]        slew_rate;
        logic               slew_enable;
        logic [23:0]        elapsed_cap_us;
        logic [7:0]         slot_map;
        logic [3:0]         orient_reverse;
        logic [63:0]        middle_offsets;
    } cfg_t;

    typedef enum logic [2:0] {
        CFG_ANGLE_MIN      = 3'd0,
        CFG_ANGLE_MAX      = 3'd1,
        CFG_SLEW_RATE      = 3'd2,
        CFG_SLEW_ENABLE    = 3'd3,
        CFG_ELAPSED_CAP_US = 3'd4,
        CFG_SLOT_MAP       = 3'd5,
        CFG_ORIENT_REVERSE = 3'd6,
        CFG_MIDDLE_OFFSETS = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_APPLY,
        ST_ENC,
        ST_STORE,
        ST_EMIT
    } state_t;

    localparam int SLOTS        = 4;
    localparam int FIFO_DEPTH   = 2;
    localparam int QUO_W        = 17;
    localparam int PROD_W       = 40;
    localparam int DIV_PRE      = 6;
    localparam int SAT_BIT      = 36;
    localparam int RECIP_W      = 31;
    localparam int RECIP_SHIFT  = 44;
    localparam int RECIP_PROD_W = 61;

    localparam logic [PROD_W-1:0]  US_PER_S   = 40'd1000000;
    localparam logic [RECIP_W-1:0] DIV_RECIP  = 31'd1125899907;
    localparam logic [QUO_W-1:0]   QUO_SAT    = 17'h1FFFF;
    localparam logic signed [24:0] TICK_GAIN = 25'sd8344303;
    localparam logic signed [43:0] TICK_BIAS = 44'sd68719476736;
    localparam logic [8:0]        TICK_MID   = 9'd256;
    localparam logic [8:0]        TICK_MAX   = 9'd511;

    localparam logic signed [13:0] RST_ANGLE_MIN   = -14'sd3217;
    localparam logic [12:0]        RST_ANGLE_MAX   = 13'd3217;
    localparam logic [15:0]        RST_SLEW_RATE   = 16'd23827;
    localparam logic [23:0]        RST_ELAPSED_CAP = 24'd270030;
    localparam logic [7:0]         RST_SLOT_MAP    = 8'd228;

endpackage

### hdl/sslte_front.sv
// ----------------------------------------------------------------------------
// sslte_front: item intake and classification
// Accepts input beats, drops sets to absent servos, holds one entry for the queue.
// ----------------------------------------------------------------------------
module sslte_front #(
    parameter int SERVO_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sslte_pkg::item_t    item_data,
    output logic                push_valid,
    input  logic                push_ready,
    output sslte_pkg::q_entry_t push_entry
);
    import sslte_pkg::*;

    logic     hold_valid_reg;
    logic     hold_valid_next;
    q_entry_t hold_reg;
    q_entry_t entry;
    logic     keep;

    always_comb
    begin
        entry.op          = (item_data.func == FUNC_TICK) ? OP_TICK : OP_SET;
        entry.servo_index = item_data.servo_index;
        entry.angle       = item_data.angle;
        entry.now_us      = item_data.now_us;
        keep = (item_data.func == FUNC_TICK) ||
               ({1'b0, item_data.servo_index} < 3'(SERVO_COUNT));
    end

    assign item_ready = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_entry = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (item_valid && item_ready)
        begin
            hold_valid_next = keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            hold_reg <= entry;
        end
    end

endmodule

### hdl/sslte_fifo.sv
// ----------------------------------------------------------------------------
// sslte_fifo: short queue between front and back
// Two-entry first-in first-out store of classified entries.
// ----------------------------------------------------------------------------
module sslte_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  sslte_pkg::q_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop,
    output sslte_pkg::q_entry_t pop_entry
);
    import sslte_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    q_entry_t         mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hdl/sslte_back.sv
// ----------------------------------------------------------------------------
// sslte_back: slot sequencer and tick encoder
// Applies set entries; for tick entries walks the four slots through slew
// multiply, reciprocal divide by one million, clamp, encode, and emits a frame.
// ----------------------------------------------------------------------------
module sslte_back #(
    parameter int SERVO_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sslte_pkg::cfg_t     cfg,
    input  logic                q_valid,
    input  sslte_pkg::q_entry_t q_entry,
    output logic                q_pop,
    output logic                frame_valid,
    input  logic                frame_ready,
    output sslte_pkg::frame_t   frame_data
);
    import sslte_pkg::*;

    localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

    state_t state_reg;
    state_t state_next;

    logic signed [15:0] req_reg      [SERVO_COUNT];
    logic signed [15:0] last_cmd_reg [SERVO_COUNT];
    logic [31:0]        last_time_reg[SERVO_COUNT];

    logic [1:0]          slot_reg;
    logic [IDX_W-1:0]    nr_reg;
    logic [31:0]         now_reg;
    logic signed [15:0]  v_reg;
    logic signed [15:0]  last_reg;
    logic [23:0]         elc_reg;
    logic                lim_reg;
    logic [PROD_W-1:0]   rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic signed [17:0]  s_reg;
    logic signed [42:0]  enc_reg;
    logic [8:0]          tick_reg [SLOTS];
    logic                frame_valid_reg;
    frame_t              frame_reg;

    logic [1:0]              nr_full;
    logic                    mapped;
    logic [IDX_W-1:0]        nr_idx;
    logic [31:0]             el;
    logic [23:0]             elc;
    logic [RECIP_PROD_W-1:0] rec_prod;
    logic [QUO_W-1:0]        quo_val;
    logic signed [22:0]  v_e;
    logic signed [22:0]  last_e;
    logic signed [22:0]  delta_e;
    logic signed [22:0]  lim_v;
    logic signed [22:0]  clamp_v;
    logic signed [22:0]  min_e;
    logic signed [22:0]  max_e;
    logic signed [15:0]  mid;
    logic signed [17:0]  s_sum;
    logic signed [17:0]  s_val;
    logic signed [43:0]  t_val;
    logic [8:0]          tick_val;
    logic                emit_ok;

    always_comb
    begin
        nr_full  = cfg.slot_map[2*slot_reg +: 2];
        mapped   = ({1'b0, nr_full} < 3'(SERVO_COUNT));
        nr_idx   = nr_full[IDX_W-1:0];
        el       = now_reg - last_time_reg[nr_idx];
        elc      = (el > {8'd0, cfg.elapsed_cap_us}) ? cfg.elapsed_cap_us : el[23:0];
        rec_prod = RECIP_PROD_W'(rem_reg[SAT_BIT-1:DIV_PRE]) * RECIP_PROD_W'(DIV_RECIP);
        quo_val  = (rem_reg[PROD_W-1:SAT_BIT] != '0) ? QUO_SAT :
                   rec_prod[RECIP_SHIFT +: QUO_W];
    end

    always_comb
    begin
        v_e     = {{7{v_reg[15]}}, v_reg};
        last_e  = {{7{last_reg[15]}}, last_reg};
        delta_e = {6'd0, quo_reg};
        min_e   = {{9{cfg.angle_min[13]}}, cfg.angle_min};
        max_e   = {10'd0, cfg.angle_max};
        lim_v   = v_e;
        if (lim_reg)
        begin
            if (v_e - last_e >= 0)
            begin
                if (v_e > last_e + delta_e)
                begin
                    lim_v = last_e + delta_e;
                end
            end
            else
            begin
                if (v_e < last_e - delta_e)
                begin
                    lim_v = last_e - delta_e;
                end
            end
        end
        clamp_v = lim_v;
        if (clamp_v < min_e)
        begin
            clamp_v = min_e;
        end
        if (clamp_v > max_e)
        begin
            clamp_v = max_e;
        end
        mid   = cfg.middle_offsets[16*nr_reg +: 16];
        s_sum = {{2{clamp_v[15]}}, clamp_v[15:0]} + {{2{mid[15]}}, mid};
        s_val = cfg.orient_reverse[nr_reg] ? -s_sum : s_sum;
    end

    always_comb
    begin
        t_val = {enc_reg[42], enc_reg} + TICK_BIAS;
        if (t_val[43])
        begin
            tick_val = '0;
        end
        else if (t_val[43:28] > 16'(TICK_MAX))
        begin
            tick_val = TICK_MAX;
        end
        else
        begin
            tick_val = t_val[36:28];
        end
    end

    assign emit_ok     = !frame_valid_reg || frame_ready;
    assign frame_valid = frame_valid_reg;
    assign frame_data  = frame_reg;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.op == OP_TICK)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                if (!mapped)
                begin
                    state_next = (slot_reg == 2'(SLOTS - 1)) ? ST_EMIT : ST_LOAD;
                end
                else if (cfg.slew_enable && (el != 32'd0))
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_ENC;
            end
            ST_ENC:
            begin
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                state_next = (slot_reg == 2'(SLOTS - 1)) ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            for (int i = 0; i < SERVO_COUNT; i++)
            begin
                req_reg[i]       <= '0;
                last_cmd_reg[i]  <= '0;
                last_time_reg[i] <= '0;
            end
        end
        else
        begin
            if ((state_reg == ST_EMIT) && emit_ok)
            begin
                frame_valid_reg <= 1'b1;
            end
            else if (frame_valid_reg && frame_ready)
            begin
                frame_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && (q_entry.op == OP_SET))
                    begin
                        req_reg[q_entry.servo_index[IDX_W-1:0]] <= q_entry.angle;
                    end
                end
                ST_APPLY:
                begin
                    last_cmd_reg[nr_reg]  <= clamp_v[15:0];
                    last_time_reg[nr_reg] <= now_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                now_reg  <= q_entry.now_us;
                slot_reg <= '0;
            end
            ST_LOAD:
            begin
                nr_reg   <= nr_idx;
                v_reg    <= req_reg[nr_idx];
                last_reg <= last_cmd_reg[nr_idx];
                elc_reg  <= elc;
                lim_reg  <= cfg.slew_enable && (el != 32'd0);
                if (!mapped)
                begin
                    tick_reg[slot_reg] <= TICK_MID;
                    slot_reg           <= slot_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                rem_reg <= PROD_W'(cfg.slew_rate) * PROD_W'(elc_reg);
            end
            ST_DIV:
            begin
                quo_reg <= quo_val;
            end
            ST_APPLY:
            begin
                s_reg <= s_val;
            end
            ST_ENC:
            begin
                enc_reg <= s_reg * TICK_GAIN;
            end
            ST_STORE:
            begin
                tick_reg[slot_reg] <= tick_val;
                slot_reg           <= slot_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    frame_reg.high_bits <= {tick_reg[3][8], tick_reg[2][8],
                                            tick_reg[1][8], tick_reg[0][8]};
                    frame_reg.slot0_low <= tick_reg[0][7:0];
                    frame_reg.slot1_low <= tick_reg[1][7:0];
                    frame_reg.slot2_low <= tick_reg[2][7:0];
                    frame_reg.slot3_low <= tick_reg[3][7:0];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### hdl/servo_slew_limit_tick_encoder_top.sv
// ----------------------------------------------------------------------------
// servo_slew_limit_tick_encoder_top: four-slot servo slew limiter and encoder
// Holds the configuration bank and joins front, queue and back.
// ----------------------------------------------------------------------------
//  channel   signals                          beat moves
//  item      item_valid/item_ready/item_data  set or tick item
//  frame     frame_valid/frame_ready/frame_data  five-field servo frame
//  config    cfg_we/cfg_index/cfg_data         one register write, no wait
//
//  A set item is applied in the back's idle step. A tick item walks the slots:
//  an unmapped slot takes only the load step, an unlimited one goes through
//  load, apply, encode and store, and a limited slot adds multiply and divide
//  steps that form the rate product and its reciprocal divide by one million.
//  The front and the two-entry queue keep taking items while the back works.
//  Reset clears all servo state and loads the register defaults.
//  A stalled frame holds the back in its emit step until the beat is taken.
// ----------------------------------------------------------------------------
module servo_slew_limit_tick_encoder_top #(
    parameter int SERVO_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sslte_pkg::item_t  item_data,
    output logic              frame_valid,
    input  logic              frame_ready,
    output sslte_pkg::frame_t frame_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import sslte_pkg::*;

    cfg_t     cfg_reg;
    logic     push_valid;
    logic     push_ready;
    q_entry_t push_entry;
    logic     pop_valid;
    logic     pop;
    q_entry_t pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_min      <= RST_ANGLE_MIN;
            cfg_reg.angle_max      <= RST_ANGLE_MAX;
            cfg_reg.slew_rate      <= RST_SLEW_RATE;
            cfg_reg.slew_enable    <= 1'b0;
            cfg_reg.elapsed_cap_us <= RST_ELAPSED_CAP;
            cfg_reg.slot_map       <= RST_SLOT_MAP;
            cfg_reg.orient_reverse <= '0;
            cfg_reg.middle_offsets <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ANGLE_MIN:      cfg_reg.angle_min      <= cfg_data[13:0];
                CFG_ANGLE_MAX:      cfg_reg.angle_max      <= cfg_data[12:0];
                CFG_SLEW_RATE:      cfg_reg.slew_rate      <= cfg_data[15:0];
                CFG_SLEW_ENABLE:    cfg_reg.slew_enable    <= cfg_data[0];
                CFG_ELAPSED_CAP_US: cfg_reg.elapsed_cap_us <= cfg_data[23:0];
                CFG_SLOT_MAP:       cfg_reg.slot_map       <= cfg_data[7:0];
                CFG_ORIENT_REVERSE: cfg_reg.orient_reverse <= cfg_data[3:0];
                CFG_MIDDLE_OFFSETS: cfg_reg.middle_offsets <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sslte_front #(
        .SERVO_COUNT(SERVO_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    sslte_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    sslte_back #(
        .SERVO_COUNT(SERVO_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (pop_valid),
        .q_entry     (pop_entry),
        .q_pop       (pop),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data)
    );

endmodule

### bench/servo_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_frame_checker: frame predictor and scoreboard for the servo encoder
// Mirrors the register bank and the per-servo state from the observed beats,
// predicts the frame of every tick beat and compares each frame beat, field
// by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module servo_frame_checker #(
    parameter int SERVO_COUNT = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  sslte_pkg::item_t  item_data,
    input  logic              frame_valid,
    input  logic              frame_ready,
    input  sslte_pkg::frame_t frame_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output int                mismatch_count,
    output int                frames_outstanding,
    output int                frames_checked
);
    import sslte_pkg::*;

    cfg_t               shadow;
    logic signed [15:0] req_angle [4];
    logic signed [15:0] last_cmd [4];
    logic [31:0]        last_time [4];
    frame_t             frame_expect_q [$];

    string field_name [5] = '{"high_bits", "slot0_low", "slot1_low", "slot2_low", "slot3_low"};

    function automatic logic [8:0] slot_tick(input int unsigned nr, input logic [31:0] now);
        longint             v;
        longint             last;
        longint             delta;
        longint             s;
        longint             t;
        logic [31:0]        el;
        logic signed [15:0] mid16;
        if (nr >= SERVO_COUNT)
        begin
            return TICK_MID;
        end
        v    = req_angle[nr];
        last = last_cmd[nr];
        el   = now - last_time[nr];
        if (el != 32'd0 && shadow.slew_enable)
        begin
            if (el > {8'd0, shadow.elapsed_cap_us})
            begin
                el = {8'd0, shadow.elapsed_cap_us};
            end
            delta = (longint'(shadow.slew_rate) * longint'(el)) / longint'(US_PER_S);
            if (v - last >= 0)
            begin
                if (v > last + delta)
                begin
                    v = last + delta;
                end
            end
            else if (v < last - delta)
            begin
                v = last - delta;
            end
        end
        if (v < longint'(shadow.angle_min))
        begin
            v = longint'(shadow.angle_min);
        end
        if (v > longint'(shadow.angle_max))
        begin
            v = longint'(shadow.angle_max);
        end
        last_cmd[nr]  = v[15:0];
        last_time[nr] = now;
        mid16 = shadow.middle_offsets[16*nr +: 16];
        s = v + longint'(mid16);
        if (shadow.orient_reverse[nr])
        begin
            s = -s;
        end
        t = s * longint'(TICK_GAIN) + longint'(TICK_BIAS);
        if (t < 0)
        begin
            return 9'd0;
        end
        t = t >>> 28;
        if (t > longint'(TICK_MAX))
        begin
            t = longint'(TICK_MAX);
        end
        return t[8:0];
    endfunction

    function automatic frame_t predict_frame(input logic [31:0] now);
        frame_t     f;
        logic [8:0] tk;
        logic [7:0] lows [4];
        int         i;
        f = '0;
        for (i = 0; i < SLOTS; i++)
        begin
            tk = slot_tick(shadow.slot_map[2*i +: 2], now);
            f.high_bits[i] = tk[8];
            lows[i] = tk[7:0];
        end
        f.slot0_low = lows[0];
        f.slot1_low = lows[1];
        f.slot2_low = lows[2];
        f.slot3_low = lows[3];
        return f;
    endfunction

    task automatic check_frame(input frame_t got);
        frame_t     want;
        logic [7:0] w [5];
        logic [7:0] g [5];
        int         i;
        if (frame_expect_q.size() == 0)
        begin
            $display("%0t: frame beat with no prediction waiting, actual %h", $time, got);
            mismatch_count++;
        end
        else
        begin
            want = frame_expect_q.pop_front();
            w[0] = {4'd0, want.high_bits};
            w[1] = want.slot0_low;
            w[2] = want.slot1_low;
            w[3] = want.slot2_low;
            w[4] = want.slot3_low;
            g[0] = {4'd0, got.high_bits};
            g[1] = got.slot0_low;
            g[2] = got.slot1_low;
            g[3] = got.slot2_low;
            g[4] = got.slot3_low;
            for (i = 0; i < 5; i++)
            begin
                if (w[i] !== g[i])
                begin
                    $display("%0t: %s expected %h actual %h", $time, field_name[i], w[i], g[i]);
                    mismatch_count++;
                end
            end
            frames_checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow.angle_min      = RST_ANGLE_MIN;
            shadow.angle_max      = RST_ANGLE_MAX;
            shadow.slew_rate      = RST_SLEW_RATE;
            shadow.slew_enable    = 1'b0;
            shadow.elapsed_cap_us = RST_ELAPSED_CAP;
            shadow.slot_map       = RST_SLOT_MAP;
            shadow.orient_reverse = 4'd0;
            shadow.middle_offsets = 64'd0;
            for (int n = 0; n < 4; n++)
            begin
                req_angle[n] = '0;
                last_cmd[n]  = '0;
                last_time[n] = '0;
            end
            frame_expect_q.delete();
            mismatch_count     = 0;
            frames_checked     = 0;
            frames_outstanding = 0;
        end
        else
        begin
            if (frame_valid && frame_ready)
            begin
                check_frame(frame_data);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ANGLE_MIN:      shadow.angle_min      = cfg_data[13:0];
                    CFG_ANGLE_MAX:      shadow.angle_max      = cfg_data[12:0];
                    CFG_SLEW_RATE:      shadow.slew_rate      = cfg_data[15:0];
                    CFG_SLEW_ENABLE:    shadow.slew_enable    = cfg_data[0];
                    CFG_ELAPSED_CAP_US: shadow.elapsed_cap_us = cfg_data[23:0];
                    CFG_SLOT_MAP:       shadow.slot_map       = cfg_data[7:0];
                    CFG_ORIENT_REVERSE: shadow.orient_reverse = cfg_data[3:0];
                    CFG_MIDDLE_OFFSETS: shadow.middle_offsets = cfg_data;
                    default:            ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                if (item_data.func == FUNC_TICK)
                begin
                    frame_expect_q.push_back(predict_frame(item_data.now_us));
                end
                else if (item_data.servo_index < SERVO_COUNT)
                begin
                    req_angle[item_data.servo_index] = item_data.angle;
                end
            end
            frames_outstanding = frame_expect_q.size();
        end
    end

endmodule

### bench/servo_slew_limit_tick_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_slew_limit_tick_encoder_top_tb: stimulus and verdict for the encoder
// Drives set and tick beats under changing register settings and idle
// patterns, stalls the frame side for long stretches, and reports the
// outcome of the frame checker that runs beside the block.
// ----------------------------------------------------------------------------
module servo_slew_limit_tick_encoder_top_tb;
    import sslte_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int TAIL_CYCLES    = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 275;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item_data;
    logic        frame_valid;
    logic        frame_ready;
    frame_t      frame_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int          mismatch_count;
    int          frames_outstanding;
    int          frames_checked;

    int          send_idle = 0;
    int          recv_idle = 0;
    bit          hold_req  = 1'b0;
    int          hold_left = 0;
    int          quiet     = 0;
    int          items_sent = 0;
    int          ticks_sent = 0;
    int          settings_used = 0;
    logic [31:0] clock_us = 32'd6000;

    servo_slew_limit_tick_encoder_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_data   (item_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    servo_frame_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_valid         (item_valid),
        .item_ready         (item_ready),
        .item_data          (item_data),
        .frame_valid        (frame_valid),
        .frame_ready        (frame_ready),
        .frame_data         (frame_data),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatch_count     (mismatch_count),
        .frames_outstanding (frames_outstanding),
        .frames_checked     (frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic cfg_t make_cfg(input int amin, input int amax, input int rate,
                                      input bit en, input int cap, input int map,
                                      input int orient, input logic [63:0] mid);
        cfg_t c;
        c.angle_min      = 14'(amin);
        c.angle_max      = 13'(amax);
        c.slew_rate      = 16'(rate);
        c.slew_enable    = en;
        c.elapsed_cap_us = 24'(cap);
        c.slot_map       = 8'(map);
        c.orient_reverse = 4'(orient);
        c.middle_offsets = mid;
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        int   n;
        c = make_cfg(0, 0, $urandom, ($urandom_range(99) < 75), 0, $urandom, $urandom, 64'd0);
        if ($urandom_range(99) < 80)
        begin
            c.angle_min = 14'(-int'($urandom_range(0, 4289)));
            c.angle_max = 13'($urandom_range(0, 4289));
        end
        else
        begin
            c.angle_min = 14'($urandom);
            c.angle_max = 13'($urandom);
        end
        if ($urandom_range(99) < 20)
        begin
            c.slew_rate = 16'($urandom_range(0, 100));
        end
        n = $urandom_range(99);
        if (n < 50)
        begin
            c.elapsed_cap_us = 24'($urandom_range(0, 50000));
        end
        else if (n < 90)
        begin
            c.elapsed_cap_us = 24'($urandom_range(1000, 400000));
        end
        else
        begin
            c.elapsed_cap_us = 24'($urandom);
        end
        for (n = 0; n < 4; n++)
        begin
            if ($urandom_range(99) < 60)
            begin
                c.middle_offsets[16*n +: 16] = 16'(int'($urandom_range(0, 3000)) - 1500);
            end
            else
            begin
                c.middle_offsets[16*n +: 16] = 16'($urandom);
            end
        end
        return c;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    n;
        it.servo_index = 2'($urandom);
        it.now_us      = $urandom;
        if ($urandom_range(99) < 70)
        begin
            it.angle = 16'(int'($urandom_range(0, 10000)) - 5000);
        end
        else
        begin
            it.angle = 16'($urandom);
        end
        if ($urandom_range(99) < 40)
        begin
            it.func = FUNC_SET;
        end
        else
        begin
            it.func = FUNC_TICK;
            n = $urandom_range(99);
            if (n < 70)
            begin
                clock_us = clock_us + $urandom_range(1, 30000);
            end
            else if (n < 80)
            begin
                clock_us = clock_us;
            end
            else if (n < 90)
            begin
                clock_us = $urandom;
            end
            else
            begin
                clock_us = clock_us + $urandom_range(100000, 2000000);
            end
            it.now_us = clock_us;
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        bit ok;
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        do
        begin
            @(negedge clk);
            ok = item_ready;
            @(posedge clk);
        end
        while (!ok);
        items_sent++;
        if (it.func == FUNC_TICK)
        begin
            ticks_sent++;
        end
    endtask

    task automatic send_set(input int idx, input int ang);
        item_t it;
        it.func        = FUNC_SET;
        it.servo_index = 2'(idx);
        it.angle       = 16'(ang);
        it.now_us      = $urandom;
        send_item(it);
    endtask

    task automatic send_tick(input logic [31:0] now);
        item_t it;
        it.func        = FUNC_TICK;
        it.servo_index = 2'($urandom);
        it.angle       = 16'($urandom);
        it.now_us      = now;
        send_item(it);
    endtask

    task automatic drain_frames();
        item_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (frames_outstanding != 0);
        @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_cfg(input cfg_t c);
        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(CFG_ANGLE_MIN, 64'(c.angle_min));
        cfg_write(CFG_ANGLE_MAX, 64'(c.angle_max));
        cfg_write(CFG_SLEW_RATE, 64'(c.slew_rate));
        cfg_write(CFG_SLEW_ENABLE, 64'(c.slew_enable));
        cfg_write(CFG_ELAPSED_CAP_US, 64'(c.elapsed_cap_us));
        cfg_write(CFG_SLOT_MAP, 64'(c.slot_map));
        cfg_write(CFG_ORIENT_REVERSE, 64'(c.orient_reverse));
        cfg_write(CFG_MIDDLE_OFFSETS, c.middle_offsets);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // frame side: random stalls, plus a long hold-off on request
    initial
    begin
        frame_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_ready <= 1'b0;
            end
            else
            begin
                frame_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial
    begin
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (frame_valid && frame_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** servo_slew_limit_tick_encoder_top: FAILED **");
        $finish;
    end

    initial
    begin
        int ph;
        int k;
        item_valid <= 1'b0;
        item_data  <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 20;
        recv_idle = 20;
        apply_cfg(make_cfg(-3217, 3217, 23827, 1'b0, 270030, 228, 0, 64'd0));
        send_set(0, 32767);
        send_set(1, -32768);
        send_set(3, -1);
        send_tick(32'd0);
        send_tick(32'hFFFF_FFFF);
        send_set(2, 4000);

        // servo 0 in every slot, full rate, clock steps back once
        apply_cfg(make_cfg(-8192, 8191, 65535, 1'b1, 24'hFF_FFFF, 8'h00, 4'hF,
                           64'h8000_7FFF_0000_F000));
        send_set(0, -32768);
        send_tick(32'd1000);
        send_tick(32'd1000);
        send_tick(32'd500);
        send_set(0, 32767);
        send_tick(32'd700);

        // zero rate, inverted limits
        apply_cfg(make_cfg(100, 50, 0, 1'b1, 100, 8'h1B, 4'h5, 64'd0));
        send_set(1, 20000);
        send_tick(32'd2000);
        send_tick(32'd3000);

        // zero cap, limits pinned at zero
        apply_cfg(make_cfg(0, 0, 1000, 1'b1, 0, 8'hE4, 4'hA, 64'h0001_FFFF_7FFF_8000));
        send_tick(32'd4000);
        send_set(2, -5);
        send_tick(32'd5000);

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 1)
            begin
                apply_cfg(make_cfg(-8192, 8191, 65535, 1'b1, 24'hFF_FFFF, 8'hFF, 4'hF,
                                   64'hFFFF_FFFF_FFFF_FFFF));
            end
            else if (ph == 3)
            begin
                apply_cfg(make_cfg(0, 0, 0, 1'b0, 0, 8'h00, 4'h0, 64'd0));
            end
            else
            begin
                apply_cfg(random_cfg());
            end
            if (ph < 2)
            begin
                send_idle = 30;
                recv_idle = 73;
            end
            else if (ph < 4)
            begin
                send_idle = 73;
                recv_idle = 30;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ((ph == 2 || ph == 4) && k == 40)
                begin
                    hold_req = 1'b1;
                end
                if (ph == 5 && k == 100)
                begin
                    drain_frames();
                end
                send_item(random_item());
            end
        end

        drain_frames();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d beats (%0d ticks) over %0d register settings.",
                 items_sent, ticks_sent, settings_used);
        $display("Frames compared: %0d, field mismatches: %0d, still waiting: %0d.",
                 frames_checked, mismatch_count, frames_outstanding);
        if (mismatch_count == 0 && frames_outstanding == 0)
        begin
            $display("** servo_slew_limit_tick_encoder_top: PASSED **");
        end
        else
        begin
            $display("** servo_slew_limit_tick_encoder_top: FAILED **");
        end
        $finish;
    end

endmodule
